### rtl/hsp_pkg.sv
`timescale 1ns / 1ps
package hsp_pkg;

  // configuration port
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  // register widths
  localparam int WidthW  = 10;
  localparam int HeightW = 16;
  localparam int CoefW   = 15;
  localparam int C0W     = 17;

  // row counter saturates well above the tallest frame
  localparam int RowW = 17;

  localparam logic [WidthW-1:0]  WidthRst  = 10'd1022;
  localparam logic [HeightW-1:0] HeightRst = 16'd1022;
  localparam logic [CoefW-1:0]   CoefRst   = 15'd3277;
  localparam logic [CoefW-1:0]   CoefMax   = 15'd16384;
  localparam logic [C0W-1:0]     UnitGain  = 17'd65536;

  // Q16.16 rounding
  localparam int FracBits  = 16;
  localparam int RoundBias = 32768;

  // queue between front and back
  localparam int QueueDepth = 4;
  localparam int QPtrW      = 2;
  localparam int QCntW      = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CfgWidth  = 2'd0,
    CfgHeight = 2'd1,
    CfgCoef   = 2'd2
  } cfg_idx_e;

  // clamped coefficient a (Q0.16) and centre weight 1-4a (Q1.16)
  typedef struct packed {
    logic [CoefW-1:0] a;
    logic [C0W-1:0]   c0;
  } coef_t;

endpackage

### rtl/hsp_queue.sv
`timescale 1ns / 1ps
module hsp_queue import hsp_pkg::*; #(
  parameter int WIDTH = 161
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o,
  output logic             nonempty_o,
  output logic [QCntW-1:0] count_o
);

  logic [WIDTH-1:0] entry_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] count_q, count_d;
  logic             do_pop;

  assign do_pop     = pop_i && (count_q != '0);
  assign nonempty_o = (count_q != '0);
  assign count_o    = count_q;
  assign pop_data_o = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + QPtrW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + QPtrW'(1) : rd_ptr_q;
    count_d  = count_q + QCntW'(push_i) - QCntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### rtl/hsp_front.sv
`timescale 1ns / 1ps
module hsp_front import hsp_pkg::*; #(
  parameter int MAX_ROW_LENGTH = 1024,
  parameter int VALUE_WIDTH    = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgIdxW-1:0]     cfg_index_i,
  input  logic [CfgDataW-1:0]    cfg_data_i,
  // input words
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [VALUE_WIDTH-1:0] cell_value_i,
  input  logic                   frame_start_i,
  // queue side
  input  logic [QCntW-1:0]       count_i,
  output logic                   push_o,
  output logic [VALUE_WIDTH-1:0] center_o,
  output logic [VALUE_WIDTH-1:0] left_o,
  output logic [VALUE_WIDTH-1:0] right_o,
  output logic [VALUE_WIDTH-1:0] up_o,
  output logic [VALUE_WIDTH-1:0] down_o,
  output logic                   last_o,
  output coef_t                  coef_o
);

  localparam int AW   = $clog2(MAX_ROW_LENGTH);
  localparam int SW   = $clog2(MAX_ROW_LENGTH + 1);
  localparam int WMax = MAX_ROW_LENGTH - 2;

  logic [WidthW-1:0]  width_q;
  logic [HeightW-1:0] height_q;
  logic [CoefW-1:0]   coef_q;

  logic [AW-1:0]   col_q, col_d;
  logic [RowW-1:0] row_q, row_d;

  logic [SW-1:0]   w_eff, stride, nxt_c;
  logic [AW-1:0]   c_start, cur_c;
  logic [RowW-1:0] r_start, cur_r, h_last;
  logic            wrap_in, wrap_out, emit, last, accept;
  logic [CoefW-1:0] a_eff;

  // stage B: read data back from the line stores
  logic                   b_valid_q, b_emit_q, b_last_q;
  logic                   b_right_ok_q, b_fwd_q;
  logic [AW-1:0]          b_col_q;
  logic [VALUE_WIDTH-1:0] b_down_q, left_q;
  logic [VALUE_WIDTH-1:0] ctr_rd_q, rgt_rd_q, abv_rd_q;

  logic [VALUE_WIDTH-1:0] ctr_mem [MAX_ROW_LENGTH];
  logic [VALUE_WIDTH-1:0] abv_mem [MAX_ROW_LENGTH];

  function automatic logic [RowW-1:0] row_inc(input logic [RowW-1:0] r);
    return (r == '1) ? r : r + RowW'(1);
  endfunction

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthRst;
      height_q <= HeightRst;
      coef_q   <= CoefRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgWidth:  width_q  <= cfg_data_i[WidthW-1:0];
        CfgHeight: height_q <= cfg_data_i[HeightW-1:0];
        CfgCoef:   coef_q   <= cfg_data_i[CoefW-1:0];
        default: ;
      endcase
    end
  end

  assign a_eff     = (coef_q > CoefMax) ? CoefMax : coef_q;
  assign coef_o.a  = a_eff;
  assign coef_o.c0 = UnitGain - {a_eff, 2'b00};

  // credit: queue entries plus the word still in stage B
  assign in_ready_o = (QCntW'(count_i) + QCntW'(b_valid_q & b_emit_q)) < QCntW'(QueueDepth);
  assign accept     = in_valid_i & in_ready_o;

  always_comb begin
    w_eff   = (32'(width_q) > 32'(WMax)) ? SW'(WMax) : SW'(width_q);
    stride  = w_eff + SW'(2);
    h_last  = RowW'(height_q) + RowW'(1);
    c_start = frame_start_i ? '0 : col_q;
    r_start = frame_start_i ? '0 : row_q;
    // column left over from a wider row starts the next row
    wrap_in = (SW'(c_start) >= stride);
    cur_c   = wrap_in ? '0 : c_start;
    cur_r   = wrap_in ? row_inc(r_start) : r_start;
    nxt_c   = SW'(cur_c) + SW'(1);
    wrap_out = (nxt_c >= stride);
    col_d   = wrap_out ? '0 : nxt_c[AW-1:0];
    row_d   = wrap_out ? row_inc(cur_r) : cur_r;
    emit    = (cur_r >= RowW'(2)) && (cur_r <= h_last) &&
              (cur_c != '0) && (SW'(cur_c) <= w_eff);
    last    = (SW'(cur_c) == w_eff) && (cur_r == h_last);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      b_valid_q <= 1'b0;
      b_emit_q  <= 1'b0;
    end else begin
      b_valid_q <= accept;
      if (accept) begin
        col_q    <= col_d;
        row_q    <= row_d;
        b_emit_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_last_q     <= last;
      b_right_ok_q <= !wrap_out;
      // above-row write of the word in stage B lands this cycle
      b_fwd_q      <= b_valid_q && (b_col_q == cur_c);
      b_col_q      <= cur_c;
      b_down_q     <= cell_value_i;
    end
    if (b_valid_q) begin
      left_q <= ctr_rd_q;
    end
  end

  // centre row store: two reads, one write
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ctr_mem[cur_c] <= cell_value_i;
    end
    ctr_rd_q <= ctr_mem[cur_c];
    rgt_rd_q <= ctr_mem[col_d];
  end

  // row above: filled with the old centre row as it is replaced
  always_ff @(posedge clk_i) begin
    if (b_valid_q) begin
      abv_mem[b_col_q] <= ctr_rd_q;
    end
    abv_rd_q <= abv_mem[cur_c];
  end

  assign push_o   = b_valid_q & b_emit_q;
  assign center_o = ctr_rd_q;
  assign left_o   = left_q;
  assign right_o  = b_right_ok_q ? rgt_rd_q : '0;
  assign up_o     = b_fwd_q ? left_q : abv_rd_q;
  assign down_o   = b_down_q;
  assign last_o   = b_last_q;

endmodule

### rtl/hsp_back.sv
`timescale 1ns / 1ps
module hsp_back import hsp_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     nonempty_i,
  input  logic [5*VALUE_WIDTH:0]   pop_data_i,
  output logic                     pop_o,
  input  coef_t                    coef_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [VALUE_WIDTH-1:0]   new_value_o,
  output logic                     last_of_frame_o
);

  localparam int VW = VALUE_WIDTH;
  localparam int SUW = VW + 2;
  localparam int PW = VW + 18;
  localparam int TW = PW + 1 - FracBits;

  logic signed [VW-1:0]  ctr, lft, rgt, upv, dnv;
  logic                  last_in;
  logic                  en;

  logic                  v1_q, v2_q, out_valid_q;
  logic                  l1_q, l2_q, out_last_q;
  logic signed [VW-1:0]  ctr1_q;
  logic signed [SUW-1:0] sum1_q, sum_d;
  logic signed [PW-1:0]  p0_q, p1_q, p0_d, p1_d;
  logic signed [17:0]    c0s;
  logic signed [15:0]    as;
  logic signed [PW:0]    tot;
  logic signed [TW-1:0]  q;
  logic [VW-1:0]         sat, out_value_q;
  logic                  fits;

  assign {last_in, ctr, lft, rgt, upv, dnv} = pop_data_i;

  // whole pipeline holds while a result waits at the output
  assign en    = !out_valid_q || out_ready_i;
  assign pop_o = en && nonempty_i;

  assign c0s = {1'b0, coef_i.c0};
  assign as  = {1'b0, coef_i.a};

  always_comb begin
    sum_d = SUW'(lft) + SUW'(rgt) + SUW'(upv) + SUW'(dnv);
    p0_d  = PW'(ctr1_q) * PW'(c0s);
    p1_d  = PW'(sum1_q) * PW'(as);
    tot   = (PW+1)'(p0_q) + (PW+1)'(p1_q) + (PW+1)'(RoundBias);
    q     = TW'(tot >>> FracBits);
    fits  = (q[TW-1:VW-1] == '0) || (q[TW-1:VW-1] == '1);
    sat   = fits ? q[VW-1:0] :
            (q[TW-1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= nonempty_i;
      v2_q        <= v1_q;
      out_valid_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ctr1_q      <= ctr;
      sum1_q      <= sum_d;
      l1_q        <= last_in;
      p0_q        <= p0_d;
      p1_q        <= p1_d;
      l2_q        <= l1_q;
      out_value_q <= sat;
      out_last_q  <= l2_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign new_value_o     = out_value_q;
  assign last_of_frame_o = out_last_q;

endmodule

### rtl/heat_stencil_5point_step_unit.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake              Word
// cfg       in         cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
// in        in         in_valid_i/in_ready_o    cell_value_i, frame_start_i
// out       out        out_valid_o/out_ready_i  new_value_o, last_of_frame_o
//
// One input word per cycle sustained while the queue has room; a result is
// offered once the word completing its stencil has passed the line-store read,
// queue, sum, products and output register. The pace is set by the line stores:
// one write and two reads of the centre row and one read and one write of the
// row above for each accepted word.
// Reset clears counters and pipeline valids, presets config; line stores hold garbage.
// A four-word queue splits front and back; input stalls only when the queue,
// counting a result word still in the store stage, has no free entry.
module heat_stencil_5point_step_unit import hsp_pkg::*; #(
  parameter int MAX_ROW_LENGTH = 1024,
  parameter int VALUE_WIDTH    = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgIdxW-1:0]     cfg_index_i,
  input  logic [CfgDataW-1:0]    cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [VALUE_WIDTH-1:0] cell_value_i,
  input  logic                   frame_start_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [VALUE_WIDTH-1:0] new_value_o,
  output logic                   last_of_frame_o
);

  // queue word: last flag then the five stencil taps
  localparam int QW = 5 * VALUE_WIDTH + 1;

  logic                   push, pop, nonempty;
  logic [QCntW-1:0]       count;
  logic [QW-1:0]          push_data, pop_data;
  logic [VALUE_WIDTH-1:0] center, left, right, up, down;
  logic                   last;
  coef_t                  coef;

  // front: position tracking, line stores and tap gathering
  hsp_front #(
    .MAX_ROW_LENGTH(MAX_ROW_LENGTH),
    .VALUE_WIDTH   (VALUE_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cell_value_i (cell_value_i),
    .frame_start_i(frame_start_i),
    .count_i      (count),
    .push_o       (push),
    .center_o     (center),
    .left_o       (left),
    .right_o      (right),
    .up_o         (up),
    .down_o       (down),
    .last_o       (last),
    .coef_o       (coef)
  );

  assign push_data = {last, center, left, right, up, down};

  hsp_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .pop_i      (pop),
    .pop_data_o (pop_data),
    .nonempty_o (nonempty),
    .count_o    (count)
  );

  // back: weighted sum, rounding, saturation, output register
  hsp_back #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .nonempty_i     (nonempty),
    .pop_data_i     (pop_data),
    .pop_o          (pop),
    .coef_i         (coef),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .new_value_o    (new_value_o),
    .last_of_frame_o(last_of_frame_o)
  );

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// Checks the 5-point heat step unit against a predictor that runs beside it.
// Cell words go in through a feed queue; every accepted word updates the
// predicted line stores and may queue one expected result word.
module testbench;
  import hsp_pkg::*;

  localparam int RowLen = 1024;
  localparam int ValW   = 32;
  localparam int MaxInteriorW = RowLen - 2;
  localparam int unsigned RowCeiling = 32'h20000;
  localparam longint MaxVal = (longint'(1) <<< (ValW - 1)) - 1;
  localparam longint MinVal = -MaxVal - 1;
  // index with no register behind it; writes there must change nothing
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;
  // cycles for words still in flight after the last result has left
  localparam int FlushCycles = 40;
  localparam int StallCycles = 300;

  typedef struct packed {
    logic [ValW-1:0] value;
    logic            start;
  } cell_word_t;

  typedef struct packed {
    logic [ValW-1:0] value;
    logic            last;
  } result_word_t;

  typedef enum int {
    SenderLight,    // sender idles 11 %, receiver 77 %
    ReceiverLight,  // sender idles 77 %, receiver 11 %
    NoIdle
  } idle_mode_e;

  // ---------------------------------------------------------------- DUT ports
  logic                   clk_i           = 1'b0;
  logic                   rst_ni          = 1'b0;
  logic                   cfg_valid_i     = 1'b0;
  logic                   cfg_ready_o;
  logic [CfgIdxW-1:0]     cfg_index_i     = '0;
  logic [CfgDataW-1:0]    cfg_data_i      = '0;
  logic                   in_valid_i      = 1'b0;
  logic                   in_ready_o;
  logic [ValW-1:0]        cell_value_i    = '0;
  logic                   frame_start_i   = 1'b0;
  logic                   out_valid_o;
  logic                   out_ready_i     = 1'b0;
  logic [ValW-1:0]        new_value_o;
  logic                   last_of_frame_o;

  heat_stencil_5point_step_unit #(
    .MAX_ROW_LENGTH(RowLen),
    .VALUE_WIDTH   (ValW)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cell_value_i   (cell_value_i),
    .frame_start_i  (frame_start_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .new_value_o    (new_value_o),
    .last_of_frame_o(last_of_frame_o)
  );

  always #1 clk_i = ~clk_i;

  // ------------------------------------------------------------ shared state
  cell_word_t   cell_feed[$];        // words waiting to be offered
  result_word_t pending_results[$];  // predicted words, oldest first
  int unsigned  error_count   = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_idle_pct = 0;
  logic         in_fire_seen  = 1'b0;
  bit           stall_request = 1'b0;

  // ---------------------------------------------------------------- predictor
  // Register copies, as written through the config port.
  logic [WidthW-1:0]  width_q  = WidthRst;
  logic [HeightW-1:0] height_q = HeightRst;
  logic [CoefW-1:0]   coef_q   = CoefRst;

  // Line stores and window. Stores start at zero here; the first frame after
  // reset writes every entry twice before any of them feeds a result.
  logic signed [ValW-1:0] above_row  [RowLen] = '{default: '0};
  logic signed [ValW-1:0] centre_row [RowLen] = '{default: '0};
  logic signed [ValW-1:0] win_left   = '0;
  logic signed [ValW-1:0] win_centre = '0;
  int unsigned            col_pos    = 0;
  int unsigned            row_pos    = 0;

  // (1-4a)*centre + a*(sum of neighbours), Q16.16, round half up, saturate.
  // Exact in 64 bits: each product stays below 2^48.
  function automatic logic [ValW-1:0] heat_update(
    input logic signed [ValW-1:0] ctr, lf, rt, up, dn
  );
    longint a;
    longint c0;
    longint acc;
    a   = (coef_q > CoefMax) ? longint'(CoefMax) : longint'(coef_q);
    c0  = longint'(UnitGain) - 4 * a;
    acc = c0 * longint'(ctr)
        + a * (longint'(lf) + longint'(rt) + longint'(up) + longint'(dn))
        + RoundBias;
    acc = acc >>> FracBits;
    if (acc > MaxVal) acc = MaxVal;
    if (acc < MinVal) acc = MinVal;
    return acc[ValW-1:0];
  endfunction

  // One raster step of the grid: move the position, read the window, queue a
  // result word for interior cells, then shift the stores.
  task automatic advance_grid(input logic [ValW-1:0] x, input logic start);
    int unsigned            w;
    int unsigned            stride;
    int unsigned            c;
    int unsigned            r;
    logic signed [ValW-1:0] centre;
    logic signed [ValW-1:0] up;
    logic signed [ValW-1:0] right;
    result_word_t           res;
    w      = (width_q > MaxInteriorW) ? MaxInteriorW : width_q;
    stride = w + 2;
    if (start) begin
      col_pos = 0;
      row_pos = 0;
    end
    // a narrower width set mid-row leaves the column past the stride
    if (col_pos >= stride) begin
      col_pos = 0;
      if (row_pos < RowCeiling) row_pos++;
    end
    c = col_pos;
    r = row_pos;
    centre = (c == 0) ? centre_row[0] : win_centre;
    up     = above_row[c];
    right  = (c + 1 < stride) ? centre_row[c + 1] : '0;
    // the top halo row, rows past the frame and halo columns give nothing
    if (r >= 2 && r <= height_q + 1 && c >= 1 && c <= w) begin
      res.value = heat_update(centre, win_left, right, up, signed'(x));
      res.last  = (c == w && r == height_q + 1);
      pending_results.push_back(res);
    end
    above_row[c]  = centre;
    centre_row[c] = x;
    win_left      = centre;
    win_centre    = right;
    col_pos = c + 1;
    if (col_pos >= stride) begin
      col_pos = 0;
      if (row_pos < RowCeiling) row_pos++;
    end
  endtask

  // ------------------------------------------------------------------ monitor
  // Everything is sampled at the rising edge; inputs moved at the falling edge before it.
  always @(posedge clk_i) begin
    result_word_t want;
    in_fire_seen <= in_valid_i && in_ready_o;
    // results first: a word accepted at this edge cannot have caused one yet
    if (out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: result with none pending: expected none, got value %h last %b",
                 $time, new_value_o, last_of_frame_o);
      end else begin
        want = pending_results.pop_front();
        if (new_value_o !== want.value) begin
          error_count++;
          $display("%0t: new_value expected %h got %h", $time, want.value, new_value_o);
        end
        if (last_of_frame_o !== want.last) begin
          error_count++;
          $display("%0t: last_of_frame expected %b got %b",
                   $time, want.last, last_of_frame_o);
        end
      end
    end
    if (in_valid_i && in_ready_o) advance_grid(cell_value_i, frame_start_i);
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgWidth:  width_q  = cfg_data_i[WidthW-1:0];
        CfgHeight: height_q = cfg_data_i[HeightW-1:0];
        CfgCoef:   coef_q   = cfg_data_i[CoefW-1:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------------- driver
  // A word stays on the port until the edge that takes it; only then may the
  // next one (or an idle gap) follow.
  always @(negedge clk_i) begin
    cell_word_t word;
    if (!in_valid_i || in_fire_seen) begin
      if (cell_feed.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        word = cell_feed.pop_front();
        in_valid_i    <= 1'b1;
        cell_value_i  <= word.value;
        frame_start_i <= word.start;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ----------------------------------------------------------------- receiver
  // Random back-pressure, plus one long hold-off so the internal queue fills
  // and the input side has to stall.
  bit stall_served = 1'b0;
  int stall_left   = 0;

  always @(negedge clk_i) begin
    if (stall_request && !stall_served) begin
      stall_served = 1'b1;
      stall_left   = StallCycles;
    end
    if (stall_left != 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------- sequencer
  task automatic set_idling(input idle_mode_e mode);
    case (mode)
      SenderLight: begin
        send_idle_pct = 11;
        recv_idle_pct = 77;
      end
      ReceiverLight: begin
        send_idle_pct = 77;
        recv_idle_pct = 11;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Unused data bits are filled at random; the block must drop them.
  task automatic set_geometry(input int unsigned w, input int unsigned h,
                              input int unsigned coef);
    logic [CfgDataW-1:0] junk;
    junk = $urandom;
    write_reg(CfgWidth, {junk[CfgDataW-1:WidthW], w[WidthW-1:0]});
    write_reg(CfgHeight, h[HeightW-1:0]);
    write_reg(CfgCoef, {junk[0], coef[CoefW-1:0]});
  endtask

  function automatic logic [ValW-1:0] pick_cell();
    case ($urandom_range(0, 9))
      0:       return {1'b0, {(ValW-1){1'b1}}};
      1:       return {1'b1, {(ValW-1){1'b0}}};
      2:       return ValW'($urandom_range(0, 32'h1F_FFFF)) - ValW'(32'h10_0000);
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_frame(input int unsigned count, input bit with_start);
    cell_word_t word;
    for (int unsigned i = 0; i < count; i++) begin
      word.value = pick_cell();
      word.start = with_start && (i == 0);
      cell_feed.push_back(word);
    end
  endtask

  // Wait until every word has gone in and every result has come out, then
  // give words that cause nothing time to leave the pipeline.
  task automatic drain_block();
    do @(posedge clk_i);
    while (cell_feed.size() != 0 || in_valid_i || pending_results.size() != 0);
    repeat (FlushCycles) @(posedge clk_i);
  endtask

  initial begin
    cell_word_t  word;
    int unsigned random_items;
    int unsigned w;
    int unsigned h;
    int unsigned coef;
    int unsigned stride;
    int unsigned total;
    int unsigned count;
    int unsigned kind;
    bit          pressure_done;
    logic [CfgDataW-1:0] junk;
    random_items  = 0;
    pressure_done = 1'b0;
    set_idling(SenderLight);
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset values, first cell without frame_start: counters already at zero.
    // Three full-stride rows also leave both line stores fully written.
    queue_frame(RowLen * 3, 1'b0);
    drain_block();

    // Coefficient above the clamp, so the centre weight is zero: the result is
    // the neighbour mean, driven to both ends of the range.
    set_geometry(1, 1, 15'h7FFF);
    for (int k = 0; k < 2; k++) begin
      for (int i = 0; i < 9; i++) begin
        if (i == 4) word.value = k ? {1'b0, {(ValW-1){1'b1}}} : {1'b1, {(ValW-1){1'b0}}};
        else if (i % 2 == 1) word.value = k ? {1'b1, {(ValW-1){1'b0}}}
                                            : {1'b0, {(ValW-1){1'b1}}};
        else word.value = $urandom;
        word.start = (i == 0);
        cell_feed.push_back(word);
      end
    end
    drain_block();

    // Zero width and zero height: no interior cells; unmapped index written.
    junk = $urandom;
    set_geometry(0, 0, 0);
    write_reg(CfgUnused, junk);
    queue_frame(6, 1'b1);
    drain_block();

    // Width past the limit is clamped to the widest row; one full frame.
    set_geometry(1023, 1, 16385);
    queue_frame(RowLen * 3, 1'b1);
    drain_block();

    // Random phases: mostly whole frames, some cut short, overrun or started
    // without frame_start. A new phase may change the width mid-row.
    while (random_items < 2000) begin
      if (random_items < 700) set_idling(SenderLight);
      else if (random_items < 1400) set_idling(ReceiverLight);
      else set_idling(NoIdle);

      if (random_items >= 1400 && !pressure_done) begin
        // long hold-off on the result side while words keep coming
        pressure_done = 1'b1;
        set_geometry(6, 6, $urandom_range(0, 16384));
        stall_request = 1'b1;
        queue_frame(8 * 8, 1'b1);
        random_items += 8 * 8;
        drain_block();
        continue;
      end

      case ($urandom_range(0, 19))
        0:       w = 0;
        1:       w = 1;
        2:       w = $urandom_range(9, 40);
        default: w = $urandom_range(1, 8);
      endcase
      case ($urandom_range(0, 19))
        0:       h = 0;
        1:       h = 65535;
        2:       h = $urandom_range(6, 12);
        default: h = $urandom_range(1, 5);
      endcase
      case ($urandom_range(0, 9))
        0:       coef = 0;
        1:       coef = 16384;
        2:       coef = $urandom_range(16385, 32767);
        3:       coef = 3277;
        default: coef = $urandom_range(0, 16384);
      endcase
      set_geometry(w, h, coef);
      stride = w + 2;

      repeat ($urandom_range(1, 3)) begin
        kind = $urandom_range(0, 9);
        if (h == 65535) begin
          // tallest frame: only its first rows
          count = stride * $urandom_range(3, 6) + $urandom_range(0, stride - 1);
        end else begin
          total = stride * (h + 2);
          case (kind)
            0:       count = $urandom_range(1, total - 1);
            1:       count = total + $urandom_range(1, 2 * stride);
            default: count = total;
          endcase
        end
        queue_frame(count, kind != 2);
        random_items += count;
      end
      drain_block();
    end

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
